// File: sv/i2c_eeprom_byte_master_macros.svh
// Assertion macros for the I2C EEPROM byte master.
// Included by the top level; no other dependencies.
`ifndef I2C_EEPROM_BYTE_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_MASTER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define IEBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define IEBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define IEBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define IEBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/iebm_pkg.sv
// Types and constants shared by the I2C EEPROM byte master modules.
// No dependencies.
`default_nettype none

package iebm_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] word_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ,
        OP_NONE
    } t_op_kind;

    typedef struct packed {
        t_op_kind   op;
        logic [7:0] word_addr;
        logic [7:0] write_data;
        logic       sda;
    } t_op;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_START1    = 14'h0002,
        ST_DEV_W     = 14'h0004,
        ST_ACK_DEV_W = 14'h0008,
        ST_WADDR     = 14'h0010,
        ST_ACK_WADDR = 14'h0020,
        ST_DATA      = 14'h0040,
        ST_ACK_DATA  = 14'h0080,
        ST_START2    = 14'h0100,
        ST_DEV_R     = 14'h0200,
        ST_ACK_DEV_R = 14'h0400,
        ST_RECV      = 14'h0800,
        ST_MACK      = 14'h1000,
        ST_STOP      = 14'h2000
    } t_state;

endpackage

`default_nettype wire

// File: sv/iebm_front.sv
// Front end: classifies incoming items and holds them in a short queue.
// Depends on iebm_pkg.
`default_nettype none

module iebm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire iebm_pkg::t_in_item i_in_item,
    output iebm_pkg::t_q_head       o_head,
    input  wire logic               i_pop
);

    iebm_pkg::t_op                   r_q_mem [iebm_pkg::QDepth];
    logic [iebm_pkg::QPtrW-1:0]      r_wr_ptr;
    logic [iebm_pkg::QPtrW-1:0]      r_rd_ptr;
    logic [iebm_pkg::QPtrW:0]        r_count;
    iebm_pkg::t_op                   w_op;
    logic                            w_full;
    logic                            w_push;
    logic                            w_pop;

    always_comb begin
        w_op.word_addr  = i_in_item.word_addr;
        w_op.write_data = i_in_item.write_data;
        w_op.sda        = i_in_item.sda_in;
        case (i_in_item.kind)
            iebm_pkg::KIND_TICK:  w_op.op = iebm_pkg::OP_TICK;
            iebm_pkg::KIND_WRITE: w_op.op = iebm_pkg::OP_WRITE;
            iebm_pkg::KIND_READ:  w_op.op = iebm_pkg::OP_READ;
            default:              w_op.op = iebm_pkg::OP_NONE;
        endcase
    end

    assign w_full     = (r_count == (iebm_pkg::QPtrW+1)'(iebm_pkg::QDepth));
    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full;
    assign w_pop      = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_q_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wr_ptr] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/iebm_back.sv
// Back end: the I2C bit sequencer with the output register, one queued item per cycle unless stalled.
// Depends on iebm_pkg.
`default_nettype none

module iebm_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_wdata,
    input  wire iebm_pkg::t_q_head  i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output iebm_pkg::t_out_item     o_out_item
);

    logic [6:0]          r_dev_addr;
    iebm_pkg::t_state    r_state, n_state;
    logic [1:0]          r_phase, n_phase;
    logic [2:0]          r_bit, n_bit;
    logic [7:0]          r_shift, n_shift;
    logic                r_read_mode, n_read_mode;
    logic [7:0]          r_addr, n_addr;
    logic [7:0]          r_data, n_data;
    logic                r_ack_good, n_ack_good;
    logic                r_out_valid;
    iebm_pkg::t_out_item r_out, n_out;
    logic                w_mid;
    logic                w_is_send;
    logic                w_is_ack;
    logic                w_scl;
    logic                w_sda;
    logic                w_done;

    assign o_pop       = i_head.valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_mid     = (r_phase == 2'd1) || (r_phase == 2'd2);
    assign w_is_send = (r_state == iebm_pkg::ST_DEV_W) || (r_state == iebm_pkg::ST_WADDR)
                    || (r_state == iebm_pkg::ST_DATA)  || (r_state == iebm_pkg::ST_DEV_R);
    assign w_is_ack  = (r_state == iebm_pkg::ST_ACK_DEV_W) || (r_state == iebm_pkg::ST_ACK_WADDR)
                    || (r_state == iebm_pkg::ST_ACK_DATA)  || (r_state == iebm_pkg::ST_ACK_DEV_R);

    // Line levels reflect the state held before this item is applied.
    always_comb begin
        case (r_state)
            iebm_pkg::ST_START1, iebm_pkg::ST_START2: begin
                w_scl = (r_phase != 2'd3);
                w_sda = (r_phase < 2'd2);
            end
            iebm_pkg::ST_STOP: begin
                w_scl = (r_phase != 2'd0);
                w_sda = (r_phase >= 2'd2);
            end
            iebm_pkg::ST_DEV_W, iebm_pkg::ST_WADDR, iebm_pkg::ST_DATA,
            iebm_pkg::ST_DEV_R: begin
                w_scl = w_mid;
                w_sda = r_shift[7];
            end
            iebm_pkg::ST_ACK_DEV_W, iebm_pkg::ST_ACK_WADDR, iebm_pkg::ST_ACK_DATA,
            iebm_pkg::ST_ACK_DEV_R, iebm_pkg::ST_RECV, iebm_pkg::ST_MACK: begin
                w_scl = w_mid;
                w_sda = 1'b1;
            end
            default: begin
                w_scl = 1'b1;
                w_sda = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_read_mode = r_read_mode;
        n_addr      = r_addr;
        n_data      = r_data;
        n_ack_good  = r_ack_good;
        w_done      = 1'b0;

        case (i_head.op.op)
            iebm_pkg::OP_TICK: begin
                if (r_state == iebm_pkg::ST_IDLE) begin
                    n_phase = 2'd0;
                end else begin
                    // Sampling happens in the middle of the high half of SCL.
                    if (r_phase == 2'd2) begin
                        if (w_is_ack) begin
                            if (!((r_state == iebm_pkg::ST_ACK_WADDR) && r_read_mode)
                                && i_head.op.sda) begin
                                n_ack_good = 1'b0;
                            end
                        end else if (r_state == iebm_pkg::ST_RECV) begin
                            n_shift = {r_shift[6:0], i_head.op.sda};
                        end
                    end
                    if (r_phase != 2'd3) begin
                        n_phase = r_phase + 2'd1;
                    end else begin
                        n_phase = 2'd0;
                        if (w_is_send) begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 3'd1;
                            if (r_bit == 3'd7) begin
                                case (r_state)
                                    iebm_pkg::ST_DEV_W: n_state = iebm_pkg::ST_ACK_DEV_W;
                                    iebm_pkg::ST_WADDR: n_state = iebm_pkg::ST_ACK_WADDR;
                                    iebm_pkg::ST_DATA:  n_state = iebm_pkg::ST_ACK_DATA;
                                    default:            n_state = iebm_pkg::ST_ACK_DEV_R;
                                endcase
                            end
                        end else if (w_is_ack && !r_ack_good) begin
                            n_state = iebm_pkg::ST_STOP;
                            n_data  = 8'd0;
                        end else begin
                            case (r_state)
                                iebm_pkg::ST_START1: begin
                                    n_state = iebm_pkg::ST_DEV_W;
                                    n_shift = {r_dev_addr, 1'b0};
                                    n_bit   = 3'd0;
                                end
                                iebm_pkg::ST_ACK_DEV_W: begin
                                    n_state = iebm_pkg::ST_WADDR;
                                    n_shift = r_addr;
                                    n_bit   = 3'd0;
                                end
                                iebm_pkg::ST_ACK_WADDR: begin
                                    if (r_read_mode) begin
                                        n_state = iebm_pkg::ST_START2;
                                    end else begin
                                        n_state = iebm_pkg::ST_DATA;
                                        n_shift = r_data;
                                        n_bit   = 3'd0;
                                    end
                                end
                                iebm_pkg::ST_ACK_DATA: n_state = iebm_pkg::ST_STOP;
                                iebm_pkg::ST_START2: begin
                                    n_state = iebm_pkg::ST_DEV_R;
                                    n_shift = {r_dev_addr, 1'b1};
                                    n_bit   = 3'd0;
                                end
                                iebm_pkg::ST_ACK_DEV_R: begin
                                    n_state = iebm_pkg::ST_RECV;
                                    n_shift = 8'd0;
                                    n_bit   = 3'd0;
                                end
                                iebm_pkg::ST_RECV: begin
                                    n_bit = r_bit + 3'd1;
                                    if (r_bit == 3'd7) begin
                                        n_data  = r_shift;
                                        n_state = iebm_pkg::ST_MACK;
                                    end
                                end
                                iebm_pkg::ST_MACK: n_state = iebm_pkg::ST_STOP;
                                iebm_pkg::ST_STOP: begin
                                    n_state = iebm_pkg::ST_IDLE;
                                    w_done  = 1'b1;
                                end
                                default: n_state = iebm_pkg::ST_IDLE;
                            endcase
                        end
                    end
                end
            end
            iebm_pkg::OP_WRITE, iebm_pkg::OP_READ: begin
                // A command is only taken while the bus is idle.
                if (r_state == iebm_pkg::ST_IDLE) begin
                    n_read_mode = (i_head.op.op == iebm_pkg::OP_READ);
                    n_addr      = i_head.op.word_addr;
                    n_data      = (i_head.op.op == iebm_pkg::OP_READ) ? 8'd0
                                                                       : i_head.op.write_data;
                    n_ack_good  = 1'b1;
                    n_shift     = 8'd0;
                    n_bit       = 3'd0;
                    n_phase     = 2'd0;
                    n_state     = iebm_pkg::ST_START1;
                end
            end
            default: begin
            end
        endcase

        n_out.scl_out   = w_scl;
        n_out.sda_out   = w_sda;
        n_out.busy_res  = (n_state != iebm_pkg::ST_IDLE);
        n_out.done_res  = w_done;
        n_out.success   = w_done && r_ack_good;
        n_out.read_data = (w_done && r_read_mode && r_ack_good) ? r_data : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= iebm_pkg::DEV_ADDR_RESET;
            r_state     <= iebm_pkg::ST_IDLE;
            r_phase     <= 2'd0;
            r_bit       <= 3'd0;
            r_shift     <= 8'd0;
            r_read_mode <= 1'b0;
            r_addr      <= 8'd0;
            r_data      <= 8'd0;
            r_ack_good  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_state     <= n_state;
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_read_mode <= n_read_mode;
                r_addr      <= n_addr;
                r_data      <= n_data;
                r_ack_good  <= n_ack_good;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: sv/i2c_eeprom_byte_master.sv
// I2C EEPROM byte master: one result item per input item, one item per clock sustained while
// the output is not stalled. Each input is a bus tick (sampled SDA) or a byte-write / random-read
// command; four ticks make one SCL bit. Items enter a four-deep queue and the sequencer applies
// one per cycle unless the output stalls. Each input item is registered in the queue and its result
// in the output register, and the output register lets the next item proceed while a result is
// still being taken. The device address register may be written only while the block is idle.
// Depends on iebm_pkg, iebm_front, iebm_back and i2c_eeprom_byte_master_macros.svh.
`default_nettype none

`include "i2c_eeprom_byte_master_macros.svh"

module i2c_eeprom_byte_master (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [6:0]          i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire iebm_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output iebm_pkg::t_out_item      o_out_item
);

    iebm_pkg::t_q_head w_head;
    logic              w_pop;

    iebm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    iebm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // A finished transaction leaves the bus idle.
    `IEBM_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_out_item.done_res, !o_out_item.busy_res)

    // Success and read data are only reported on the completing item.
    `IEBM_ASSERT_IMP(a_success_on_done, i_clk, i_rst_n, o_out_valid && o_out_item.success, o_out_item.done_res)

    `IEBM_ASSERT_IMP(a_rdata_on_success, i_clk, i_rst_n, o_out_valid && (o_out_item.read_data != 8'd0), o_out_item.success)

    // A queued item with room at the output must produce a result next cycle.
    `IEBM_ASSERT_NXT(a_queue_drains, i_clk, i_rst_n, w_head.valid && !(o_out_valid && i_out_stall), o_out_valid)

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the I2C EEPROM byte master. An in-line bus model follows each
// write and random-read transfer and answers ACK and read data. Every result item is checked.
// Depends on iebm_pkg and the i2c_eeprom_byte_master RTL.
module tb;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int ITEM_TARGET  = 1150;
    localparam int DRAIN_CYCLES = 6;
    localparam int PRINT_LIMIT  = 40;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [6:0]          i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    iebm_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b1;
    iebm_pkg::t_out_item o_out_item;

    // Bus sequencer model of the master.
    iebm_pkg::t_state m_state = iebm_pkg::ST_IDLE;
    logic [3:0] m_bit = '0;
    logic [1:0] m_phase = '0;
    logic [7:0] m_shift = '0;
    logic       m_rd = 1'b0;
    logic [7:0] m_addr = '0;
    logic [7:0] m_data = '0;
    logic       m_ack = 1'b1;
    logic [6:0] m_dev = iebm_pkg::DEV_ADDR_RESET;

    iebm_pkg::t_out_item expected_bus_q[$];
    int         in_gap_max = 6;
    int         out_gap_max = 6;
    int         mismatches = 0;
    int         n_items = 0;
    int         n_writes = 0;
    int         n_reads = 0;
    int         n_good = 0;
    int         n_aborted = 0;
    int         n_addr_writes = 0;

    i2c_eeprom_byte_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic bit is_send_state(input iebm_pkg::t_state s);
        return s == iebm_pkg::ST_DEV_W || s == iebm_pkg::ST_WADDR
            || s == iebm_pkg::ST_DATA  || s == iebm_pkg::ST_DEV_R;
    endfunction

    function automatic bit is_ack_state(input iebm_pkg::t_state s);
        return s == iebm_pkg::ST_ACK_DEV_W || s == iebm_pkg::ST_ACK_WADDR
            || s == iebm_pkg::ST_ACK_DATA  || s == iebm_pkg::ST_ACK_DEV_R;
    endfunction

    // Advances the sequencer by one tick; returns 1 on the tick that completes STOP.
    function automatic bit advance_bus(input logic sda);
        if (m_state == iebm_pkg::ST_IDLE) begin
            m_phase = '0;
            return 1'b0;
        end
        if (m_phase == 2'd2) begin
            if (is_ack_state(m_state)) begin
                // The word address ACK of a random read is clocked but not checked.
                if (!(m_state == iebm_pkg::ST_ACK_WADDR && m_rd) && sda)
                    m_ack = 1'b0;
            end else if (m_state == iebm_pkg::ST_RECV) begin
                m_shift = {m_shift[6:0], sda};
            end
        end
        if (m_phase != 2'd3) begin
            m_phase++;
            return 1'b0;
        end
        m_phase = '0;
        if (is_send_state(m_state)) begin
            m_shift = m_shift << 1;
            m_bit++;
            if (m_bit == 4'd8) begin
                m_bit = '0;
                case (m_state)
                    iebm_pkg::ST_DEV_W: m_state = iebm_pkg::ST_ACK_DEV_W;
                    iebm_pkg::ST_WADDR: m_state = iebm_pkg::ST_ACK_WADDR;
                    iebm_pkg::ST_DATA:  m_state = iebm_pkg::ST_ACK_DATA;
                    default:            m_state = iebm_pkg::ST_ACK_DEV_R;
                endcase
            end
            return 1'b0;
        end
        if (is_ack_state(m_state) && !m_ack) begin
            m_state = iebm_pkg::ST_STOP;
            m_data  = '0;
            return 1'b0;
        end
        case (m_state)
            iebm_pkg::ST_START1: begin
                m_state = iebm_pkg::ST_DEV_W;
                m_shift = {m_dev, 1'b0};
                m_bit   = '0;
            end
            iebm_pkg::ST_ACK_DEV_W: begin
                m_state = iebm_pkg::ST_WADDR;
                m_shift = m_addr;
                m_bit   = '0;
            end
            iebm_pkg::ST_ACK_WADDR: begin
                if (m_rd) begin
                    m_state = iebm_pkg::ST_START2;
                end else begin
                    m_state = iebm_pkg::ST_DATA;
                    m_shift = m_data;
                    m_bit   = '0;
                end
            end
            iebm_pkg::ST_ACK_DATA: m_state = iebm_pkg::ST_STOP;
            iebm_pkg::ST_START2: begin
                m_state = iebm_pkg::ST_DEV_R;
                m_shift = {m_dev, 1'b1};
                m_bit   = '0;
            end
            iebm_pkg::ST_ACK_DEV_R: begin
                m_state = iebm_pkg::ST_RECV;
                m_shift = '0;
                m_bit   = '0;
            end
            iebm_pkg::ST_RECV: begin
                m_bit++;
                if (m_bit == 4'd8) begin
                    m_bit   = '0;
                    m_data  = m_shift;
                    m_state = iebm_pkg::ST_MACK;
                end
            end
            iebm_pkg::ST_MACK: m_state = iebm_pkg::ST_STOP;
            default: begin
                m_state = iebm_pkg::ST_IDLE;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Applies one accepted item to the model and returns the result item it must produce.
    function automatic iebm_pkg::t_out_item predict_bus_result(input iebm_pkg::t_in_item it);
        iebm_pkg::t_out_item r;
        logic                mid;
        r   = '0;
        mid = (m_phase == 2'd1) || (m_phase == 2'd2);
        case (m_state)
            iebm_pkg::ST_START1, iebm_pkg::ST_START2: begin
                r.scl_out = (m_phase != 2'd3);
                r.sda_out = (m_phase < 2'd2);
            end
            iebm_pkg::ST_STOP: begin
                r.scl_out = (m_phase != 2'd0);
                r.sda_out = (m_phase >= 2'd2);
            end
            iebm_pkg::ST_IDLE: begin
                r.scl_out = 1'b1;
                r.sda_out = 1'b1;
            end
            default: begin
                r.scl_out = mid;
                r.sda_out = is_send_state(m_state) ? m_shift[7] : 1'b1;
            end
        endcase
        if (it.kind == iebm_pkg::KIND_TICK) begin
            if (advance_bus(it.sda_in)) begin
                r.done_res  = 1'b1;
                r.success   = m_ack;
                r.read_data = (m_rd && m_ack) ? m_data : 8'h00;
                if (m_ack)
                    n_good++;
                else
                    n_aborted++;
            end
        end else if ((it.kind == iebm_pkg::KIND_WRITE || it.kind == iebm_pkg::KIND_READ)
                     && m_state == iebm_pkg::ST_IDLE) begin
            m_rd    = (it.kind == iebm_pkg::KIND_READ);
            m_addr  = it.word_addr;
            m_data  = m_rd ? 8'h00 : it.write_data;
            m_ack   = 1'b1;
            m_shift = '0;
            m_bit   = '0;
            m_phase = '0;
            m_state = iebm_pkg::ST_START1;
        end
        r.busy_res = (m_state != iebm_pkg::ST_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        iebm_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bus_q.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                e = expected_bus_q.pop_front();
                if (o_out_item.scl_out !== e.scl_out)
                    report_mismatch($sformatf("scl_out %b, want %b", o_out_item.scl_out,
                                              e.scl_out));
                if (o_out_item.sda_out !== e.sda_out)
                    report_mismatch($sformatf("sda_out %b, want %b", o_out_item.sda_out,
                                              e.sda_out));
                if (o_out_item.busy_res !== e.busy_res)
                    report_mismatch($sformatf("busy_res %b, want %b", o_out_item.busy_res,
                                              e.busy_res));
                if (o_out_item.done_res !== e.done_res)
                    report_mismatch($sformatf("done_res %b, want %b", o_out_item.done_res,
                                              e.done_res));
                if (o_out_item.success !== e.success)
                    report_mismatch($sformatf("success %b, want %b", o_out_item.success,
                                              e.success));
                if (o_out_item.read_data !== e.read_data)
                    report_mismatch($sformatf("read_data %h, want %h", o_out_item.read_data,
                                              e.read_data));
            end
        end
    end

    // The result side stalls a random number of cycles before taking each item.
    initial begin : result_stall
        int wait_n;
        @(posedge i_clk);
        forever begin
            wait_n = $urandom_range(0, out_gap_max);
            if (wait_n != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_item(input iebm_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_items++;
        expected_bus_q.push_back(predict_bus_result(it));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_bus_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_device_address(input logic [6:0] a);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_dev = a;
        n_addr_writes++;
    endtask

    // SDA level that the EEPROM side presents for the next tick.
    function automatic logic eeprom_sda(input logic [13:0] nack_mask, input int nack_pct,
                                        input logic [7:0] rom_byte);
        if (m_phase != 2'd2)
            return 1'($urandom_range(0, 1));
        if (is_ack_state(m_state))
            return ((nack_mask & m_state) != 0) || ($urandom_range(0, 99) < nack_pct);
        if (m_state == iebm_pkg::ST_RECV)
            return rom_byte[3'd7 - m_bit[2:0]];
        return 1'($urandom_range(0, 1));
    endfunction

    // Items sent while a transfer runs: commands and reserved kinds that must be ignored.
    function automatic iebm_pkg::t_in_item busy_noise();
        iebm_pkg::t_in_item it;
        it.word_addr  = 8'($urandom);
        it.write_data = 8'($urandom);
        it.sda_in     = 1'($urandom);
        case ($urandom_range(0, 2))
            0:       it.kind = iebm_pkg::KIND_WRITE;
            1:       it.kind = iebm_pkg::KIND_READ;
            default: it.kind = KIND_RESERVED;
        endcase
        return it;
    endfunction

    task automatic run_transfer(input logic [1:0] kind, input logic [7:0] waddr,
                                input logic [7:0] wdata, input logic [7:0] rom_byte,
                                input logic [13:0] nack_mask, input int nack_pct,
                                input int noise_pct);
        iebm_pkg::t_in_item it;
        it = '{kind: kind, word_addr: waddr, write_data: wdata, sda_in: 1'($urandom)};
        if (kind == iebm_pkg::KIND_READ)
            n_reads++;
        else
            n_writes++;
        send_item(it);
        while (m_state != iebm_pkg::ST_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                it = busy_noise();
            end else begin
                it.kind       = iebm_pkg::KIND_TICK;
                it.word_addr  = 8'($urandom);
                it.write_data = 8'($urandom);
                it.sda_in     = eeprom_sda(nack_mask, nack_pct, rom_byte);
            end
            send_item(it);
        end
    endtask

    // Ticks and reserved kinds while idle; none of them may start anything.
    task automatic idle_noise(input int count);
        iebm_pkg::t_in_item it;
        repeat (count) begin
            it.kind       = $urandom_range(0, 1) ? iebm_pkg::KIND_TICK : KIND_RESERVED;
            it.word_addr  = 8'($urandom);
            it.write_data = 8'($urandom);
            it.sda_in     = 1'($urandom);
            send_item(it);
        end
    endtask

    task automatic test_idle_inputs();
        send_item('{kind: iebm_pkg::KIND_TICK, word_addr: 8'h00, write_data: 8'h00,
                    sda_in: 1'b0});
        send_item('{kind: iebm_pkg::KIND_TICK, word_addr: 8'hFF, write_data: 8'hFF,
                    sda_in: 1'b1});
        send_item('{kind: KIND_RESERVED, word_addr: 8'hFF, write_data: 8'h00, sda_in: 1'b1});
        send_item('{kind: KIND_RESERVED, word_addr: 8'h00, write_data: 8'hFF, sda_in: 1'b0});
    endtask

    // The first read runs with the device address left at its reset value. The second one
    // sees a NACK on the word address, which a random read does not check.
    task automatic test_reads();
        run_transfer(iebm_pkg::KIND_READ, 8'h5A, 8'hFF, 8'hA5, '0, 0, 0);
        run_transfer(iebm_pkg::KIND_READ, 8'hFF, 8'h00, 8'hFF, iebm_pkg::ST_ACK_WADDR, 0, 0);
    endtask

    task automatic test_write_extremes();
        set_device_address(7'h7F);
        run_transfer(iebm_pkg::KIND_WRITE, 8'hFF, 8'h00, 8'h00, '0, 0, 0);
    endtask

    task automatic test_busy_commands();
        set_device_address(7'h00);
        run_transfer(iebm_pkg::KIND_WRITE, 8'h00, 8'hFF, 8'h00, '0, 0, 30);
    endtask

    task automatic test_nack_aborts();
        set_device_address(iebm_pkg::DEV_ADDR_RESET);
        run_transfer(iebm_pkg::KIND_WRITE, 8'h12, 8'h34, 8'h00, iebm_pkg::ST_ACK_DEV_W, 0, 0);
        run_transfer(iebm_pkg::KIND_WRITE, 8'h56, 8'h78, 8'h00, iebm_pkg::ST_ACK_WADDR, 0, 0);
        run_transfer(iebm_pkg::KIND_WRITE, 8'h9A, 8'hBC, 8'h00, iebm_pkg::ST_ACK_DATA, 0, 0);
        run_transfer(iebm_pkg::KIND_READ, 8'hDE, 8'h00, 8'hF0, iebm_pkg::ST_ACK_DEV_R, 0, 0);
    endtask

    task automatic test_random_traffic();
        int phase;
        int nack_pct;
        phase = 0;
        while (n_items < ITEM_TARGET) begin
            case (phase % 4)
                0:       begin in_gap_max = 0; out_gap_max = 6; end
                1:       begin in_gap_max = 0; out_gap_max = 0; end
                2:       begin in_gap_max = 6; out_gap_max = 6; end
                default: begin in_gap_max = 6; out_gap_max = 0; end
            endcase
            if (phase % 2 == 0)
                set_device_address(7'($urandom));
            if ($urandom_range(0, 3) == 0)
                idle_noise($urandom_range(1, 4));
            case ($urandom_range(0, 2))
                0:       nack_pct = 0;
                1:       nack_pct = 3;
                default: nack_pct = 15;
            endcase
            run_transfer($urandom_range(0, 1) ? iebm_pkg::KIND_READ : iebm_pkg::KIND_WRITE,
                         8'($urandom), 8'($urandom), 8'($urandom), '0, nack_pct,
                         $urandom_range(0, 8));
            phase++;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_inputs();
        test_reads();
        test_write_extremes();
        test_busy_commands();
        test_nack_aborts();
        test_random_traffic();
        drain_results();
        $display("Sent %0d input items: %0d writes and %0d reads, %0d completed, %0d aborted.",
                 n_items, n_writes, n_reads, n_good, n_aborted);
        $display("Device address was set %0d times; %0d mismatches found.",
                 n_addr_writes, mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
